// ----- hdl/blop_pkg.sv -----
`timescale 1ns / 1ps

package blop_pkg;

  typedef struct packed {
    logic [31:0] spot_price;
    logic [31:0] strike_price;
    logic        option_kind;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] option_value;
    logic               saturated;
  } out_item_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GROSS_RETURN   = 2'd0;
  localparam logic [1:0] CFG_UP_FACTOR      = 2'd1;
  localparam logic [1:0] CFG_DIVIDEND_YIELD = 2'd2;
  localparam logic [1:0] CFG_NODE_COUNT     = 2'd3;

  localparam logic [31:0] RST_GROSS_RETURN = 32'd1073741824;
  localparam logic [31:0] RST_UP_FACTOR    = 32'd1181116006;
  localparam logic [30:0] RST_DIVIDEND     = 31'd0;
  localparam logic [6:0]  RST_NODE_COUNT   = 7'd2;

  localparam logic [39:0] VAL_MAX   = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] VAL_MIN   = 40'h80_0000_0000;
  localparam logic [63:0] PRICE_CAP = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_Q30   = 64'h0000_0000_4000_0000;
  localparam logic [63:0] TWO_P60   = 64'h1000_0000_0000_0000;

  localparam logic [6:0] DIV_STEPS_FULL = 7'd64;
  localparam logic [6:0] DIV_STEPS_FOLD = 7'd40;

  typedef struct packed {
    logic       start;
    logic [6:0] steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DINV,
    S_DINV_WAIT,
    S_PROB,
    S_PROB_WAIT,
    S_PSET,
    S_MUL,
    S_TERM_U,
    S_TERM_UDONE,
    S_TERM_PAY,
    S_TERM_DDONE,
    S_FOLD_RD0,
    S_FOLD_RD1,
    S_FOLD_PREP,
    S_FOLD_CHK,
    S_FOLD_DIV,
    S_FOLD_WAIT,
    S_FOLD_WR,
    S_ROOT_RD,
    S_ROOT,
    S_DONE
  } state_e;

endpackage

// ----- hdl/blop_ram.sv -----
`timescale 1ns / 1ps

module blop_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/blop_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The starting remainder must be
// below the divisor; the dividend bits are shifted in from the top.
module blop_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blop_pkg::div_req_t req_i,
  input  logic [31:0]        divisor_i,
  input  logic [31:0]        rem0_i,
  input  logic [63:0]        bits_i,
  output blop_pkg::div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [31:0] rem_q, dvs_q;
  logic [63:0] bits_q, quo_q;
  logic [32:0] sh;
  logic        ge;
  logic [32:0] diff;

  assign sh   = {rem_q, bits_q[63]};
  assign ge   = sh >= {1'b0, dvs_q};
  assign diff = sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= rem0_i;
      dvs_q  <= divisor_i;
      bits_q <= bits_i;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[31:0] : sh[31:0];
      bits_q <= {bits_q[62:0], 1'b0};
      quo_q  <= {quo_q[62:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- hdl/binomial_lattice_option_pricer.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                 | Payload
// in       | input     | in_valid_i / in_stall_o   | in_data_i  (blop_pkg::in_item_t)
// out      | output    | out_valid_o / out_stall_i | out_data_o (blop_pkg::out_item_t)
// cfg      | input     | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// One item at a time. An item goes through the two setup divisions, the up scaling
// steps (N*(N-1)/2 steps), the payoff and the next down step for each terminal node,
// and a multiply and, unless the value saturates, a division for each folded node
// (N*(N-1)/2 nodes); the fold divisions run on the one-bit-per-cycle divider.
// The 32x32 multiplier is shared by all products, the node values live in one RAM.
// in_stall_o is high while an item is in work; a finished result waits in the
// output register and the next item is taken meanwhile. Reset needs no clearing pass.
module binomial_lattice_option_pricer #(
  parameter int MAX_NODES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  blop_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output blop_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW = $clog2(MAX_NODES + 1);

  blop_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [31:0] gross_q, up_q;
  logic [30:0] divy_q;
  logic [6:0]  nodes_q;

  logic [31:0]   strike_q, strike_d;
  logic          put_q, put_d;
  logic [NW-1:0] n_q, n_d, n_sel;
  logic [31:0]   d_q, d_d;
  logic [63:0]   p_q, p_d, pm_q, pm_d, cm_q, cm_d;
  logic          psg_q, psg_d, pn_q, pn_d, cn_q, cn_d;
  logic [63:0]   dc_q, dc_d, s_q, s_d;
  logic [IW-1:0] i_q, i_d, k_q, k_d, len_q, len_d;
  logic          mode_q, mode_d;
  logic [63:0]   x_q, x_d;
  logic [31:0]   f_q, f_d;
  logic [3:0]    pp_q, pp_d, pp_cnt;
  logic          pend_q, pend_d;
  logic [63:0]   mp_q, mp_d;
  logic [1:0]    sh_q, sh_d;
  logic          ng_q, ng_d;
  logic [127:0]  acc_q, acc_d, term;
  logic [47:0]   v0_q, v0_d;
  logic [39:0]   vm0_q, vm0_d, vm1_q, vm1_d;
  logic          vn0_q, vn0_d, vn1_q, vn1_d;
  logic          neg_q, neg_d;
  logic [127:0]  mag_q, mag_d;
  logic [39:0]   val_q, val_d;
  logic          sat_q, sat_d;
  logic          out_valid_q, out_valid_d;
  blop_pkg::out_item_t out_q, out_d;

  logic          in_xfer, mul_last;
  logic [31:0]   r_eff;
  logic [63:0]   scaled, pay;
  logic [33:0]   num, numm;
  logic [32:0]   den, denm;
  logic [63:0]   c_val;
  logic [39:0]   rv1, q40;
  logic          big_q;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [47:0]   mem_wdata, mem_rdata;

  blop_pkg::div_req_t div_req;
  blop_pkg::div_rsp_t div_rsp;
  logic [31:0] div_dvs, div_rem0;
  logic [63:0] div_bits;

  blop_ram #(.WIDTH(48), .DEPTH(MAX_NODES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  blop_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (div_dvs),
    .rem0_i    (div_rem0),
    .bits_i    (div_bits),
    .rsp_o     (div_rsp)
  );

  assign in_stall_o  = (state_q != blop_pkg::S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign r_eff  = (gross_q == 32'd0) ? 32'd1 : gross_q;
  assign pp_cnt = mode_q ? 4'd8 : 4'd2;
  assign mul_last = (pp_q == pp_cnt) && pend_q;

  // Price scaling result: drop 30 fraction bits, cap at 2^63.
  assign scaled = ((acc_q[127:94] != '0) || (acc_q[93:30] > blop_pkg::PRICE_CAP))
                  ? blop_pkg::PRICE_CAP : acc_q[93:30];

  assign num  = {2'b0, gross_q} - {2'b0, d_q} - {3'b0, divy_q};
  assign den  = {1'b0, up_q} - {1'b0, d_q};
  assign numm = num[33] ? (34'd0 - num) : num;
  assign denm = den[32] ? (33'd0 - den) : den;
  assign c_val = blop_pkg::ONE_Q30 - p_q;
  assign rv1   = mem_rdata[39:0];
  assign q40   = div_rsp.quotient[39:0];
  assign big_q = (mag_q[127:40] >= {56'd0, r_eff});

  always_comb begin
    if (s_q > {32'd0, strike_q} && !put_q) begin
      pay = s_q - {32'd0, strike_q};
    end else if ({32'd0, strike_q} > s_q && put_q) begin
      pay = {32'd0, strike_q} - s_q;
    end else begin
      pay = '0;
    end
  end

  always_comb begin
    if (nodes_q == 7'd0) begin
      n_sel = NW'(1);
    end else if (int'(nodes_q) > MAX_NODES) begin
      n_sel = NW'(MAX_NODES);
    end else begin
      n_sel = NW'(nodes_q);
    end
  end

  // Next partial product and the term it adds to the accumulator.
  logic [63:0] pa;
  logic [39:0] pb;
  logic [31:0] a32, b32;
  always_comb begin
    pa  = pp_q[2] ? cm_q : pm_q;
    pb  = pp_q[2] ? vm0_q : vm1_q;
    a32 = x_q[31:0];
    b32 = f_q;
    sh_d = sh_q;
    ng_d = ng_q;
    if (mode_q) begin
      a32  = pp_q[1] ? pa[63:32] : pa[31:0];
      b32  = pp_q[0] ? {24'd0, pb[39:32]} : pb[31:0];
      ng_d = pp_q[2] ? (cn_q ^ vn0_q) : (pn_q ^ vn1_q);
      case (pp_q[1:0])
        2'd0:    sh_d = 2'd0;
        2'd3:    sh_d = 2'd2;
        default: sh_d = 2'd1;
      endcase
    end else begin
      a32  = pp_q[0] ? x_q[63:32] : x_q[31:0];
      ng_d = 1'b0;
      sh_d = pp_q[0] ? 2'd1 : 2'd0;
    end
    mp_d = 64'(a32) * 64'(b32);
  end

  always_comb begin
    case (sh_q)
      2'd0:    term = {64'd0, mp_q};
      2'd1:    term = {32'd0, mp_q, 32'd0};
      default: term = {mp_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gross_q <= blop_pkg::RST_GROSS_RETURN;
      up_q    <= blop_pkg::RST_UP_FACTOR;
      divy_q  <= blop_pkg::RST_DIVIDEND;
      nodes_q <= blop_pkg::RST_NODE_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        blop_pkg::CFG_GROSS_RETURN:   gross_q <= cfg_wdata_i;
        blop_pkg::CFG_UP_FACTOR:      up_q    <= cfg_wdata_i;
        blop_pkg::CFG_DIVIDEND_YIELD: divy_q  <= cfg_wdata_i[30:0];
        blop_pkg::CFG_NODE_COUNT:     nodes_q <= cfg_wdata_i[6:0];
        default:                      gross_q <= gross_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      blop_pkg::S_IDLE:       if (in_xfer) state_d = blop_pkg::S_DINV;
      blop_pkg::S_DINV: begin
        state_d = (up_q == 32'd0) ? blop_pkg::S_PROB : blop_pkg::S_DINV_WAIT;
      end
      blop_pkg::S_DINV_WAIT:  if (div_rsp.done) state_d = blop_pkg::S_PROB;
      blop_pkg::S_PROB: begin
        state_d = (den == '0) ? blop_pkg::S_PSET : blop_pkg::S_PROB_WAIT;
      end
      blop_pkg::S_PROB_WAIT:  if (div_rsp.done) state_d = blop_pkg::S_PSET;
      blop_pkg::S_PSET:       state_d = blop_pkg::S_TERM_U;
      blop_pkg::S_MUL:        if (mul_last) state_d = ret_q;
      blop_pkg::S_TERM_U: begin
        state_d = (k_q == '0) ? blop_pkg::S_TERM_PAY : blop_pkg::S_MUL;
      end
      blop_pkg::S_TERM_UDONE: state_d = blop_pkg::S_TERM_U;
      blop_pkg::S_TERM_PAY: begin
        if (i_q != '0) begin
          state_d = blop_pkg::S_MUL;
        end else if (n_q == NW'(1)) begin
          state_d = blop_pkg::S_ROOT_RD;
        end else begin
          state_d = blop_pkg::S_FOLD_RD0;
        end
      end
      blop_pkg::S_TERM_DDONE: state_d = blop_pkg::S_TERM_U;
      blop_pkg::S_FOLD_RD0:   state_d = blop_pkg::S_FOLD_RD1;
      blop_pkg::S_FOLD_RD1:   state_d = blop_pkg::S_FOLD_PREP;
      blop_pkg::S_FOLD_PREP:  state_d = blop_pkg::S_MUL;
      blop_pkg::S_FOLD_CHK:   state_d = blop_pkg::S_FOLD_DIV;
      blop_pkg::S_FOLD_DIV: begin
        state_d = big_q ? blop_pkg::S_FOLD_WR : blop_pkg::S_FOLD_WAIT;
      end
      blop_pkg::S_FOLD_WAIT:  if (div_rsp.done) state_d = blop_pkg::S_FOLD_WR;
      blop_pkg::S_FOLD_WR: begin
        if (i_q == len_q - IW'(1) && len_q == IW'(1)) begin
          state_d = blop_pkg::S_ROOT_RD;
        end else begin
          state_d = blop_pkg::S_FOLD_RD0;
        end
      end
      blop_pkg::S_ROOT_RD:    state_d = blop_pkg::S_ROOT;
      blop_pkg::S_ROOT:       state_d = blop_pkg::S_DONE;
      blop_pkg::S_DONE:       if (!out_valid_q || !out_stall_i) state_d = blop_pkg::S_IDLE;
      default:                state_d = blop_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ret_d = ret_q;
    strike_d = strike_q; put_d = put_q; n_d = n_q;
    d_d = d_q; p_d = p_q; psg_d = psg_q;
    pm_d = pm_q; pn_d = pn_q; cm_d = cm_q; cn_d = cn_q;
    dc_d = dc_q; s_d = s_q; i_d = i_q; k_d = k_q; len_d = len_q;
    mode_d = mode_q; x_d = x_q; f_d = f_q;
    pp_d = pp_q; pend_d = 1'b0; acc_d = acc_q;
    v0_d = v0_q; vm0_d = vm0_q; vn0_d = vn0_q; vm1_d = vm1_q; vn1_d = vn1_q;
    neg_d = neg_q; mag_d = mag_q; val_d = val_q; sat_d = sat_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we = 1'b0; mem_waddr = i_q; mem_wdata = {{8{val_q[39]}}, val_q};
    mem_raddr = '0;
    div_req.start = 1'b0; div_req.steps = blop_pkg::DIV_STEPS_FULL;
    div_dvs = up_q; div_rem0 = '0; div_bits = blop_pkg::TWO_P60;

    unique case (state_q)
      blop_pkg::S_IDLE: begin
        if (in_xfer) begin
          strike_d = in_data_i.strike_price;
          put_d    = in_data_i.option_kind;
          n_d      = n_sel;
          sat_d    = 1'b0;
          dc_d     = {32'd0, in_data_i.spot_price};
          s_d      = {32'd0, in_data_i.spot_price};
          i_d      = IW'(n_sel - NW'(1));
          k_d      = IW'(n_sel - NW'(1));
        end
      end
      blop_pkg::S_DINV: begin
        if (up_q == 32'd0) begin
          d_d = 32'hFFFF_FFFF;
        end else begin
          div_req.start = 1'b1;
        end
      end
      blop_pkg::S_DINV_WAIT: begin
        if (div_rsp.done) begin
          d_d = (div_rsp.quotient[63:32] != '0) ? 32'hFFFF_FFFF : div_rsp.quotient[31:0];
        end
      end
      blop_pkg::S_PROB: begin
        psg_d = num[33] ^ den[32];
        if (den == '0) begin
          p_d = '0;
        end else begin
          div_req.start = 1'b1;
          div_dvs  = denm[31:0];
          div_bits = {numm, 30'd0};
        end
      end
      blop_pkg::S_PROB_WAIT: begin
        if (div_rsp.done) begin
          p_d = psg_q ? (64'd0 - div_rsp.quotient) : div_rsp.quotient;
        end
      end
      blop_pkg::S_PSET: begin
        pn_d = p_q[63];
        pm_d = p_q[63] ? (64'd0 - p_q) : p_q;
        cn_d = c_val[63];
        cm_d = c_val[63] ? (64'd0 - c_val) : c_val;
      end
      blop_pkg::S_MUL: begin
        if (pp_q < pp_cnt) begin
          pend_d = 1'b1;
          pp_d   = pp_q + 4'd1;
        end
        if (pend_q) begin
          acc_d = ng_q ? (acc_q - term) : (acc_q + term);
        end
      end
      blop_pkg::S_TERM_U: begin
        if (k_q != '0) begin
          x_d = s_q; f_d = up_q; mode_d = 1'b0;
          acc_d = '0; pp_d = '0;
          ret_d = blop_pkg::S_TERM_UDONE;
        end
      end
      blop_pkg::S_TERM_UDONE: begin
        s_d = scaled;
        k_d = k_q - IW'(1);
      end
      blop_pkg::S_TERM_PAY: begin
        mem_we = 1'b1;
        if (pay > {24'd0, blop_pkg::VAL_MAX}) begin
          sat_d     = 1'b1;
          mem_wdata = {8'd0, blop_pkg::VAL_MAX};
        end else begin
          mem_wdata = {8'd0, pay[39:0]};
        end
        if (i_q != '0) begin
          x_d = dc_q; f_d = d_q; mode_d = 1'b0;
          acc_d = '0; pp_d = '0;
          ret_d = blop_pkg::S_TERM_DDONE;
        end else begin
          len_d = IW'(n_q - NW'(1));
        end
      end
      blop_pkg::S_TERM_DDONE: begin
        dc_d = scaled;
        s_d  = scaled;
        i_d  = i_q - IW'(1);
        k_d  = i_q - IW'(1);
      end
      blop_pkg::S_FOLD_RD0: begin
        mem_raddr = i_q;
      end
      blop_pkg::S_FOLD_RD1: begin
        mem_raddr = i_q + IW'(1);
        v0_d      = mem_rdata;
      end
      blop_pkg::S_FOLD_PREP: begin
        vn0_d  = v0_q[39];
        vm0_d  = v0_q[39] ? (40'd0 - v0_q[39:0]) : v0_q[39:0];
        vn1_d  = rv1[39];
        vm1_d  = rv1[39] ? (40'd0 - rv1) : rv1;
        mode_d = 1'b1;
        acc_d  = '0;
        pp_d   = '0;
        ret_d  = blop_pkg::S_FOLD_CHK;
      end
      blop_pkg::S_FOLD_CHK: begin
        neg_d = acc_q[127];
        mag_d = acc_q[127] ? (128'd0 - acc_q) : acc_q;
      end
      blop_pkg::S_FOLD_DIV: begin
        if (big_q) begin
          sat_d = 1'b1;
          val_d = neg_q ? blop_pkg::VAL_MIN : blop_pkg::VAL_MAX;
        end else begin
          div_req.start = 1'b1;
          div_req.steps = blop_pkg::DIV_STEPS_FOLD;
          div_dvs  = r_eff;
          div_rem0 = mag_q[71:40];
          div_bits = {mag_q[39:0], 24'd0};
        end
      end
      blop_pkg::S_FOLD_WAIT: begin
        if (div_rsp.done) begin
          if (neg_q) begin
            if (q40 > blop_pkg::VAL_MIN) begin
              sat_d = 1'b1;
              val_d = blop_pkg::VAL_MIN;
            end else begin
              val_d = 40'd0 - q40;
            end
          end else if (q40[39]) begin
            sat_d = 1'b1;
            val_d = blop_pkg::VAL_MAX;
          end else begin
            val_d = q40;
          end
        end
      end
      blop_pkg::S_FOLD_WR: begin
        mem_we = 1'b1;
        if (i_q == len_q - IW'(1)) begin
          i_d   = '0;
          len_d = len_q - IW'(1);
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      blop_pkg::S_ROOT_RD: begin
        mem_raddr = '0;
      end
      blop_pkg::S_ROOT: begin
        val_d = rv1;
      end
      blop_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.option_value = val_q;
          out_d.saturated    = sat_q;
        end
      end
      default: ret_d = ret_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blop_pkg::S_IDLE;
      ret_q       <= blop_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      pp_q        <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      pp_q        <= pp_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    strike_q <= strike_d; put_q <= put_d; n_q <= n_d;
    d_q <= d_d; p_q <= p_d; psg_q <= psg_d;
    pm_q <= pm_d; pn_q <= pn_d; cm_q <= cm_d; cn_q <= cn_d;
    dc_q <= dc_d; s_q <= s_d; i_q <= i_d; k_q <= k_d; len_q <= len_d;
    mode_q <= mode_d; x_q <= x_d; f_q <= f_d;
    mp_q <= mp_d; sh_q <= sh_d; ng_q <= ng_d; acc_q <= acc_d;
    v0_q <= v0_d; vm0_q <= vm0_d; vn0_q <= vn0_d; vm1_q <= vm1_d; vn1_q <= vn1_d;
    neg_q <= neg_d; mag_q <= mag_d; val_q <= val_d; sat_q <= sat_d;
    out_q <= out_d;
  end

endmodule

// ----- hdl/blop_chk.sv -----
`timescale 1ns / 1ps

module blop_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // A waiting result stays until it is transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  // Once an item is taken, the block is busy on the next cycle.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  // A new result only appears at the end of an item in work.
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in work");

  // After a result is taken, the next one only comes from an item in work.
  a_next_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> (!out_valid_o || $past(in_stall_o)))
    else $error("result repeated");

endmodule

bind binomial_lattice_option_pricer blop_chk u_blop_chk (.*);
